@@ sv/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned StatW  = 3;

  localparam logic [CpW-1:0] CP_MAX = 21'h10FFFF;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_ABOVE_MAX = 3'd3,
    ST_TRUNC     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] byte_count;
    status_t           status;
  } res_word_t;

endpackage

@@ sv/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: bytes in, code points with byte count and
// status out.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_stall, in_data_byte,       | in
//           | in_end_of_input                         |
//  result   | out_valid, out_stall, out_code_point,   | out
//           | out_byte_count, out_status              |
//
// One byte word per clock sustained while the result side does not stall. A byte
// sits in the input register, is decoded against the sequence state and its
// result, if any, lands in the result register, from which it is offered.
// Bytes that only start or extend a sequence give no result word.
// Synchronous active-low reset empties both registers and clears the state.
// A stall on the result side holds the input register only when the byte
// there would produce a result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_end_of_input,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [u8d_pkg::CpW-1:0]    out_code_point,
  output logic [u8d_pkg::CountW-1:0] out_byte_count,
  output logic [u8d_pkg::StatW-1:0]  out_status
);
  import u8d_pkg::*;

  in_word_t  in_word, word;
  res_word_t res, out_word;
  logic      word_valid, consume, res_valid, out_ready;

  assign in_word = '{data_byte: in_data_byte, end_of_input: in_end_of_input};

  u8d_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .word_valid (word_valid),
    .word       (word),
    .consume    (consume)
  );

  u8d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word       (word),
    .out_ready  (out_ready),
    .consume    (consume),
    .res_valid  (res_valid),
    .res        (res)
  );

  u8d_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_code_point = out_word.code_point;
  assign out_byte_count = out_word.byte_count;
  assign out_status     = out_word.status;

endmodule

@@ sv/u8d_in_reg.sv @@
// ----------------------------------------------------------------------------
// u8d_in_reg
// Input register: captures one byte word and holds it until the decoder
// consumes it.
// ----------------------------------------------------------------------------
module u8d_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8d_pkg::in_word_t in_word,
  output logic              word_valid,
  output u8d_pkg::in_word_t word,
  input  logic              consume
);
  import u8d_pkg::*;

  logic     valid_r, valid_nxt;
  in_word_t word_r, word_nxt;

  assign in_stall = valid_r && !consume;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      word_nxt  = in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

@@ sv/u8d_core.sv @@
// ----------------------------------------------------------------------------
// u8d_core
// Sequence state and per-byte decode: lead classification, continuation
// shift, range check and error handling.
// ----------------------------------------------------------------------------
module u8d_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               word_valid,
  input  u8d_pkg::in_word_t  word,
  input  logic               out_ready,
  output logic               consume,
  output logic               res_valid,
  output u8d_pkg::res_word_t res
);
  import u8d_pkg::*;

  logic [1:0]        rem_r, rem_nxt;
  logic [CountW-1:0] len_r, len_nxt;
  logic [CpW-1:0]    acc_r, acc_nxt;

  logic [1:0]        rem_d;
  logic [CountW-1:0] len_d;
  logic [CpW-1:0]    acc_d;
  logic [CpW-1:0]    acc_shift;
  logic [7:0]        b;
  logic              has_res;

  assign b         = word.data_byte;
  assign acc_shift = {acc_r[CpW-7:0], b[5:0]};

  always_comb begin
    rem_d   = rem_r;
    len_d   = len_r;
    acc_d   = acc_r;
    has_res = 1'b0;
    res     = '{code_point: '0, byte_count: '0, status: ST_OK};
    if (rem_r == 2'd0) begin
      priority if (!b[7]) begin
        has_res        = 1'b1;
        res.code_point = {{(CpW-7){1'b0}}, b[6:0]};
        res.byte_count = CountW'(1);
      end else if (b[7:5] == 3'b110) begin
        rem_d = 2'd1;
        len_d = CountW'(2);
        acc_d = {{(CpW-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        rem_d = 2'd2;
        len_d = CountW'(3);
        acc_d = {{(CpW-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        rem_d = 2'd3;
        len_d = CountW'(4);
        acc_d = {{(CpW-3){1'b0}}, b[2:0]};
      end else begin
        has_res    = 1'b1;
        res.status = ST_BAD_LEAD;
      end
      // a multi-byte lead on the last byte is already truncated
      if (b[7:6] == 2'b11 && !has_res && word.end_of_input) begin
        has_res    = 1'b1;
        res.status = ST_TRUNC;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        has_res    = 1'b1;
        res.status = ST_BAD_CONT;
      end else if (rem_r == 2'd1) begin
        has_res = 1'b1;
        if (acc_shift > CP_MAX) begin
          res.status = ST_ABOVE_MAX;
        end else begin
          res.code_point = acc_shift;
          res.byte_count = len_r;
        end
      end else begin
        rem_d = rem_r - 2'd1;
        acc_d = acc_shift;
        if (word.end_of_input) begin
          has_res    = 1'b1;
          res.status = ST_TRUNC;
        end
      end
    end
    // every result ends the sequence
    if (has_res) begin
      rem_d = 2'd0;
      len_d = '0;
      acc_d = '0;
    end
  end

  assign consume   = word_valid && (!has_res || out_ready);
  assign res_valid = word_valid && has_res;

  always_comb begin
    rem_nxt = rem_r;
    len_nxt = len_r;
    acc_nxt = acc_r;
    if (consume) begin
      rem_nxt = rem_d;
      len_nxt = len_d;
      acc_nxt = acc_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      len_r <= '0;
      acc_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      len_r <= len_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

@@ sv/u8d_out_reg.sv @@
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result register: holds one decoded word for the downstream side.
// ----------------------------------------------------------------------------
module u8d_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u8d_pkg::res_word_t res,
  output logic               out_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output u8d_pkg::res_word_t out_word
);
  import u8d_pkg::*;

  logic      valid_r, valid_nxt;
  res_word_t word_r, word_nxt;

  assign out_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    if (out_ready) begin
      valid_nxt = load;
      if (load) begin
        word_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_stream_decoder. Bytes go in through the
// valid/stall input channel. A behavioral decoder in the bench tracks the
// sequence state and queues the code point, byte count and status that each
// byte should produce. Every result word is compared in order with that
// queue. Directed lead, continuation, error and truncation cases come first,
// then random byte streams under several idle and stall mixes, then a long
// result-side hold-off.
// ----------------------------------------------------------------------------
module tb;
  import u8d_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [7:0]          in_data_byte    = 8'h00;
  logic                in_end_of_input = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [CpW-1:0]      out_code_point;
  logic [CountW-1:0]   out_byte_count;
  logic [StatW-1:0]    out_status;

  // decoder state mirrored by the bench
  logic [1:0]          cont_left    = '0;
  logic [2:0]          seq_len      = '0;
  logic [CpW-1:0]      cp_bits      = '0;

  res_word_t           pending_code_points[$];
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  logic                hold_start    = 1'b0;
  int                  hold_left     = 0;
  int                  idle_cycles   = 0;
  int                  bytes_sent    = 0;
  int                  results_seen  = 0;
  int                  error_count   = 0;
  int                  status_seen[5];

  utf8_stream_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status)
  );

  always #1 clk = ~clk;

  function automatic void clear_sequence();
    cont_left = '0;
    seq_len   = '0;
    cp_bits   = '0;
  endfunction

  // Advance the mirrored state by one byte; return 1 when a result word is due.
  function automatic bit decode_byte(input logic [7:0] b, input logic eoi,
                                     output res_word_t r);
    logic [2:0] len;
    logic [6:0] payload;
    r = '0;
    r.status = ST_OK;
    if (cont_left == 2'd0) begin
      casez (b)
        8'b0???????: begin
          r.code_point = CpW'(b[6:0]);
          r.byte_count = 3'd1;
          return 1'b1;
        end
        8'b110?????: begin len = 3'd2; payload = {2'b00, b[4:0]}; end
        8'b1110????: begin len = 3'd3; payload = {3'b000, b[3:0]}; end
        8'b11110???: begin len = 3'd4; payload = {4'b0000, b[2:0]}; end
        default: begin
          clear_sequence();
          r.status = ST_BAD_LEAD;
          return 1'b1;
        end
      endcase
      if (eoi) begin
        clear_sequence();
        r.status = ST_TRUNC;
        return 1'b1;
      end
      cp_bits   = CpW'(payload);
      seq_len   = len;
      cont_left = len[1:0] - 2'd1;
      return 1'b0;
    end
    if (b[7:6] != 2'b10) begin
      clear_sequence();
      r.status = ST_BAD_CONT;
      return 1'b1;
    end
    cp_bits   = {cp_bits[CpW-7:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left == 2'd0) begin
      if (cp_bits > CP_MAX) begin
        r.status = ST_ABOVE_MAX;
      end else begin
        r.code_point = cp_bits;
        r.byte_count = seq_len;
      end
      clear_sequence();
      return 1'b1;
    end
    if (eoi) begin
      clear_sequence();
      r.status = ST_TRUNC;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one byte word, idling first at the current rate; hold until taken.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    res_word_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    if (decode_byte(b, eoi, r)) pending_code_points.push_back(r);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] rnd;
    rnd = 8'($urandom);
    case (len)
      1:       return {1'b0, rnd[6:0]};
      2:       return {3'b110, rnd[4:0]};
      3:       return {4'b1110, rnd[3:0]};
      default: return {5'b11110, rnd[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] rnd;
    rnd = 8'($urandom);
    return {2'b10, rnd[5:0]};
  endfunction

  function automatic logic [7:0] non_cont_byte();
    logic [7:0] rnd;
    rnd = 8'($urandom);
    if (rnd[7:6] == 2'b10) rnd[6] = 1'b1;
    return rnd;
  endfunction

  // One random group: mostly well-formed characters, some broken, some noise.
  task automatic send_random_group(output int n);
    int kind;
    int len;
    int cut;
    logic [7:0] seq_bytes[4];
    kind = $urandom_range(99);
    if (kind >= 85) begin
      send_byte(8'($urandom), $urandom_range(9) == 0);
      n = 1;
      return;
    end
    len = (kind < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
    seq_bytes[0] = lead_byte(len);
    for (int i = 1; i < len; i++) seq_bytes[i] = cont_byte();
    if (kind < 70) begin
      for (int i = 0; i < len; i++)
        send_byte(seq_bytes[i], (i == len - 1) && ($urandom_range(99) < 15));
      n = len;
    end else begin
      cut = $urandom_range(1, len - 1);
      if ($urandom_range(1) == 0) begin
        // cut short by end of input
        for (int i = 0; i < cut; i++) send_byte(seq_bytes[i], i == cut - 1);
        n = cut;
      end else begin
        for (int i = 0; i < cut; i++) send_byte(seq_bytes[i], 1'b0);
        send_byte(non_cont_byte(), 1'($urandom_range(1)));
        n = cut + 1;
      end
    end
  endtask

  task automatic test_valid_sequences();
    send_idle_pct = 0;
    stall_pct    <= 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    // largest legal value, end of input on the final continuation
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_bad_bytes();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b0);
    // bad continuation wins over end of input
    send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b1);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_truncation();
    send_byte(8'hE2, 1'b1);
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b1);
    wait_results_drained();
  endtask

  task automatic run_random_phase(input int idle, input int stall, input int count);
    int sent;
    int n;
    sent          = 0;
    send_idle_pct = idle;
    stall_pct    <= stall;
    while (sent < count) begin
      send_random_group(n);
      sent += n;
    end
    wait_results_drained();
  endtask

  task automatic test_random_streams();
    run_random_phase(0, 0, 110);
    run_random_phase(64, 0, 110);
    run_random_phase(0, 64, 110);
    run_random_phase(20, 20, 110);
  endtask

  // Hold the result side off while the input keeps coming, so the pipe fills.
  task automatic test_backpressure();
    int n;
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_start   <= 1'b1;
    @(posedge clk);
    hold_start   <= 1'b0;
    for (int i = 0; i < 20; i++) send_byte({1'b0, 7'($urandom)}, 1'b0);
    for (int i = 0; i < 15; i++) send_random_group(n);
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    res_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_status <= 3'd4) status_seen[out_status]++;
      if (pending_code_points.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: cp=%h count=%0d status=%0d",
                   out_code_point, out_byte_count, out_status);
      end else begin
        want = pending_code_points.pop_front();
        if (out_code_point !== want.code_point || out_byte_count !== want.byte_count ||
            out_status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: cp %h/%h count %0d/%0d status %0d/%0d (exp/got)",
                     want.code_point, out_code_point, want.byte_count,
                     out_byte_count, want.status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_valid_sequences();
    test_bad_bytes();
    test_truncation();
    test_random_streams();
    test_backpressure();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (pending_code_points.size() != 0) begin
      error_count++;
      $display("%0d results never arrived", pending_code_points.size());
    end
    $display("summary: %0d bytes in, %0d results (ok %0d, bad lead %0d, bad cont %0d,",
             bytes_sent, results_seen, status_seen[ST_OK], status_seen[ST_BAD_LEAD],
             status_seen[ST_BAD_CONT]);
    $display("summary: above max %0d, truncated %0d), %0d failures",
             status_seen[ST_ABOVE_MAX], status_seen[ST_TRUNC], error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
